### rtl/swd_pkg.sv
package swd_pkg;

    // Word and result geometry
    localparam int DATA_W      = 32;
    localparam int POS_W       = 3;
    localparam int DEPTH_DEF   = 8;
    localparam int MAX_RESULTS = 8;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_DUMP   = 2'd2,
        OP_PEEK   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } state_t;

    // Per-cycle commands broadcast to every cell
    typedef struct packed {
        logic push;    // write value into the cell at index count
        logic remove;  // close the gap at the topmost match
    } cell_ctl_t;

endpackage

### rtl/swd_req_if.sv
interface swd_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic signed [swd_pkg::DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

### rtl/swd_rsp_if.sv
interface swd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [swd_pkg::POS_W-1:0]     position;
    logic signed [swd_pkg::DATA_W-1:0] data;
    logic                          last;

    modport source (output valid, output status, output position, output data, output last,
                    input ready);
    modport sink   (input valid, input status, input position, input data, input last,
                    output ready);
endinterface

### rtl/swd_cell.sv
module swd_cell #(
    parameter int DEPTH = swd_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                          clk,
    input  swd_pkg::cell_ctl_t            ctl,
    input  logic [$clog2(DEPTH+1)-1:0]    count,
    input  logic [$clog2(DEPTH)-1:0]      rd_idx,
    input  logic [swd_pkg::DATA_W-1:0]    value,
    input  logic [swd_pkg::DATA_W-1:0]    up_data,
    input  logic                          above_in,
    input  logic [swd_pkg::DATA_W-1:0]    rd_in,
    input  logic [$clog2(DEPTH)-1:0]      pos_in,
    output logic [swd_pkg::DATA_W-1:0]    data_out,
    output logic                          above_out,
    output logic [swd_pkg::DATA_W-1:0]    rd_out,
    output logic [$clog2(DEPTH)-1:0]      pos_out
);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int IDX_W = $clog2(DEPTH);

    logic [swd_pkg::DATA_W-1:0] data_reg;
    logic                       valid;
    logic                       match;
    logic                       top_hit;

    // Match against the search word; only live entries count
    assign valid     = CNT_W'(IDX) < count;
    assign match     = valid && (data_reg == value);
    assign top_hit   = match && !above_in;
    assign above_out = above_in || match;

    // Position of the topmost match rides down the chain
    assign pos_out = top_hit ? IDX_W'(IDX) : pos_in;

    // Readout: OR in this entry when it is the one addressed
    assign rd_out = (rd_idx == IDX_W'(IDX)) ? (rd_in | data_reg) : rd_in;

    assign data_out = data_reg;

    // Load on push at the top slot, shift down at and above the deleted entry
    always_ff @(posedge clk)
    begin
        if (ctl.push && (count == CNT_W'(IDX)))
        begin
            data_reg <= value;
        end
        else if (ctl.remove && !above_in)
        begin
            data_reg <= up_data;
        end
    end

endmodule

### rtl/stack_with_delete_by_value.sv
// LIFO stack of signed 32-bit words with delete by value.
// req channel carries opcode and value: push, remove by value, dump, peek.
// rsp channel returns status, position, data and last for each result word.
// Push, remove and peek give one result word with last set. Dump gives one
// word per entry from top to bottom (at most eight, the topmost), last set
// on the final one; an empty stack gives a single error word.
// Each entry sits in its own cell; all cells compare against the search word
// in parallel and shift down in the same cycle, so for push, remove and peek
// a new request is taken every cycle while rsp keeps up.
// A dump is read out one word per cycle while rsp keeps up, paced by the
// readout into the single output register; no request is taken until the
// final dump word is loaded.
// The result word is valid the cycle after the request is accepted.
// A stalled rsp holds the output register and deasserts req.ready.
// Reset empties the stack and drops any pending result; entry contents are
// not cleared.
module stack_with_delete_by_value #(
    parameter int DEPTH = swd_pkg::DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    swd_req_if.sink    req,
    swd_rsp_if.source  rsp
);
    localparam int CNT_W = $clog2(DEPTH+1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int REM_W = $clog2(swd_pkg::MAX_RESULTS);
    localparam int DW    = swd_pkg::DATA_W;
    localparam int PW    = swd_pkg::POS_W;

    swd_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               ov_reg, ov_next;
    swd_pkg::status_t   st_reg, st_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [DW-1:0]      dat_reg, dat_next;
    logic               last_reg, last_next;

    swd_pkg::cell_ctl_t ctl;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   top_idx;
    logic               out_free;
    logic               accept;
    logic               full;
    logic               empty;
    logic               found;
    logic [IDX_W-1:0]   hit_idx;
    logic [DW-1:0]      rd_data;

    // Chain wiring between cells
    logic [DW-1:0]      cell_data [DEPTH];
    logic               above_c   [DEPTH+1];
    logic [DW-1:0]      rd_c      [DEPTH+1];
    logic [IDX_W-1:0]   pos_c     [DEPTH+1];

    assign above_c[DEPTH] = 1'b0;
    assign rd_c[DEPTH]    = '0;
    assign pos_c[DEPTH]   = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [DW-1:0] up_data;
            if (g == DEPTH-1)
            begin : g_top
                assign up_data = cell_data[g];
            end
            else
            begin : g_mid
                assign up_data = cell_data[g+1];
            end

            swd_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .count     (count_reg),
                .rd_idx    (rd_idx),
                .value     (req.value),
                .up_data   (up_data),
                .above_in  (above_c[g+1]),
                .rd_in     (rd_c[g+1]),
                .pos_in    (pos_c[g+1]),
                .data_out  (cell_data[g]),
                .above_out (above_c[g]),
                .rd_out    (rd_c[g]),
                .pos_out   (pos_c[g])
            );
        end
    endgenerate

    assign found   = above_c[0];
    assign hit_idx = pos_c[0];
    assign rd_data = rd_c[0];

    // Stack status
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign top_idx = IDX_W'(count_reg - CNT_W'(1));
    assign rd_idx  = (state_reg == swd_pkg::S_DUMP) ? idx_reg : top_idx;

    // Handshake
    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == swd_pkg::S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    // Stack index to 3-bit position (modulo 8)
    function automatic logic [PW-1:0] to_pos(input logic [IDX_W-1:0] x);
        logic [IDX_W+PW-1:0] ext;
        begin
            ext    = {{PW{1'b0}}, x};
            to_pos = ext[PW-1:0];
        end
    endfunction

    // Next state, cell commands and result word
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        ov_next    = ov_reg && !rsp.ready;
        st_next    = st_reg;
        pos_next   = pos_reg;
        dat_next   = dat_reg;
        last_next  = last_reg;
        ctl        = '0;

        case (state_reg)
            swd_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ov_next   = 1'b1;
                    last_next = 1'b1;
                    st_next   = swd_pkg::ST_OK;
                    pos_next  = '0;
                    dat_next  = '0;
                    case (swd_pkg::opcode_t'(req.opcode))
                        swd_pkg::OP_PUSH:
                        begin
                            if (full)
                            begin
                                st_next = swd_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.push   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                pos_next   = to_pos(IDX_W'(count_reg));
                                dat_next   = req.value;
                            end
                        end
                        swd_pkg::OP_REMOVE:
                        begin
                            if (empty)
                            begin
                                st_next = swd_pkg::ST_EMPTY;
                            end
                            else if (!found)
                            begin
                                st_next = swd_pkg::ST_NOTFOUND;
                            end
                            else
                            begin
                                ctl.remove = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                pos_next   = to_pos(hit_idx);
                                dat_next   = req.value;
                            end
                        end
                        swd_pkg::OP_DUMP:
                        begin
                            if (empty)
                            begin
                                st_next = swd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                pos_next = to_pos(top_idx);
                                dat_next = rd_data;
                                if (count_reg != CNT_W'(1))
                                begin
                                    last_next  = 1'b0;
                                    state_next = swd_pkg::S_DUMP;
                                    idx_next   = IDX_W'(count_reg - CNT_W'(2));
                                    if (32'(count_reg) > 32'(swd_pkg::MAX_RESULTS))
                                    begin
                                        rem_next = REM_W'(swd_pkg::MAX_RESULTS - 1);
                                    end
                                    else
                                    begin
                                        rem_next = REM_W'(count_reg - CNT_W'(1));
                                    end
                                end
                            end
                        end
                        swd_pkg::OP_PEEK:
                        begin
                            if (empty)
                            begin
                                st_next = swd_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                pos_next = to_pos(top_idx);
                                dat_next = rd_data;
                            end
                        end
                        default:
                        begin
                            st_next = swd_pkg::ST_EMPTY;
                        end
                    endcase
                end
            end
            swd_pkg::S_DUMP:
            begin
                // one entry per free output slot, walking down
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    st_next   = swd_pkg::ST_OK;
                    pos_next  = to_pos(idx_reg);
                    dat_next  = rd_data;
                    last_next = (rem_reg == REM_W'(1));
                    idx_next  = idx_reg - IDX_W'(1);
                    rem_next  = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = swd_pkg::S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = swd_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swd_pkg::S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            rem_reg   <= rem_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        st_reg   <= st_next;
        pos_reg  <= pos_next;
        dat_reg  <= dat_next;
        last_reg <= last_next;
    end

    assign rsp.valid    = ov_reg;
    assign rsp.status   = st_reg;
    assign rsp.position = pos_reg;
    assign rsp.data     = dat_reg;
    assign rsp.last     = last_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("stack count above depth");

    a_dump_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swd_pkg::S_DUMP) |-> (rem_reg != '0))
        else $error("dump walk with nothing left");

    a_notlast_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !last_reg) |-> (state_reg == swd_pkg::S_DUMP))
        else $error("non-final word outside a dump");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.opcode == swd_pkg::OP_PUSH) && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the stack");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.opcode == swd_pkg::OP_REMOVE) && found)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("remove did not shrink the stack");

endmodule

### tb/sv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH    = swd_pkg::DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DW             = swd_pkg::DATA_W;
    localparam int PW             = swd_pkg::POS_W;

    // One expected result word
    typedef struct {
        swd_pkg::status_t     status;
        logic [PW-1:0]        position;
        logic signed [DW-1:0] data;
        logic                 last;
    } rsp_word_t;

    logic clk;
    logic rst_n;

    swd_req_if req_bus ();
    swd_rsp_if rsp_bus ();

    stack_with_delete_by_value #(
        .DEPTH (STACK_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow stack, index 0 is the bottom
    logic signed [DW-1:0] stack_words [STACK_DEPTH];
    int                   stack_fill;
    rsp_word_t            pending_words [$];
    rsp_word_t            oldest_word;
    int                   errors;
    int                   idle_cycles;

    // Idling knobs, in percent per word / per cycle
    int req_idle_pct;
    int rsp_stall_pct;

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap_len();
        if ($urandom_range(99) < 85)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic void queue_result(swd_pkg::status_t st, int pos,
                                         logic signed [DW-1:0] word, logic fin);
        rsp_word_t w;
        w.status   = st;
        w.position = pos[PW-1:0];
        w.data     = word;
        w.last     = fin;
        pending_words.push_back(w);
    endfunction

    // Apply one accepted request to the shadow stack and queue its result words
    function automatic void apply_stack_op(swd_pkg::opcode_t op, logic signed [DW-1:0] val);
        int hit;
        int n;
        hit = -1;
        case (op)
            swd_pkg::OP_PUSH:
            begin
                if (stack_fill >= STACK_DEPTH)
                    queue_result(swd_pkg::ST_FULL, 0, '0, 1'b1);
                else
                begin
                    stack_words[stack_fill] = val;
                    queue_result(swd_pkg::ST_OK, stack_fill, val, 1'b1);
                    stack_fill++;
                end
            end
            swd_pkg::OP_REMOVE:
            begin
                if (stack_fill == 0)
                    queue_result(swd_pkg::ST_EMPTY, 0, '0, 1'b1);
                else
                begin
                    // topmost match wins
                    for (int i = stack_fill - 1; i >= 0 && hit < 0; i--)
                        if (stack_words[i] == val)
                            hit = i;
                    if (hit < 0)
                        queue_result(swd_pkg::ST_NOTFOUND, 0, '0, 1'b1);
                    else
                    begin
                        for (int j = hit; j + 1 < stack_fill; j++)
                            stack_words[j] = stack_words[j + 1];
                        stack_fill--;
                        queue_result(swd_pkg::ST_OK, hit, val, 1'b1);
                    end
                end
            end
            swd_pkg::OP_DUMP:
            begin
                if (stack_fill == 0)
                    queue_result(swd_pkg::ST_EMPTY, 0, '0, 1'b1);
                else
                begin
                    n = (stack_fill < swd_pkg::MAX_RESULTS) ? stack_fill
                                                            : swd_pkg::MAX_RESULTS;
                    for (int i = stack_fill - 1; i >= stack_fill - n; i--)
                        queue_result(swd_pkg::ST_OK, i, stack_words[i],
                                     i == stack_fill - n);
                end
            end
            default:
            begin
                if (stack_fill == 0)
                    queue_result(swd_pkg::ST_EMPTY, 0, '0, 1'b1);
                else
                    queue_result(swd_pkg::ST_OK, stack_fill - 1,
                                 stack_words[stack_fill - 1], 1'b1);
            end
        endcase
    endfunction

    // Send one request word; called right after a rising edge
    task automatic send_word(swd_pkg::opcode_t op, logic signed [DW-1:0] val);
        int gap;
        gap = 0;
        if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct)
            gap = pick_gap_len();
        if (gap > 0)
        begin
            req_bus.valid  <= 1'b0;
            req_bus.opcode <= 2'($urandom_range(3));
            req_bus.value  <= $urandom();
            repeat (gap) @(posedge clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.opcode <= op;
        req_bus.value  <= val;
        do
            @(posedge clk);
        while (!req_bus.ready);
        apply_stack_op(op, val);
    endtask

    // Response side back-pressure
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (pick_gap_len()) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
        end
    end

    function automatic void check_field(string name, logic [DW-1:0] exp_v,
                                        logic [DW-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (pending_words.size() == 0)
            begin
                $error("result word with nothing expected: status %0d position %0d data %h",
                       rsp_bus.status, rsp_bus.position, rsp_bus.data);
                errors++;
            end
            else
            begin
                oldest_word = pending_words.pop_front();
                check_field("status", 32'(oldest_word.status), 32'(rsp_bus.status));
                check_field("position", 32'(oldest_word.position), 32'(rsp_bus.position));
                check_field("data", oldest_word.data, rsp_bus.data);
                check_field("last", 32'(oldest_word.last), 32'(rsp_bus.last));
            end
        end
    end

    // Watchdog: cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** stack_with_delete_by_value: FAILED **");
            $finish;
        end
    end

    // Error words on an empty stack
    task automatic test_empty_stack();
        send_word(swd_pkg::OP_REMOVE, 32'sh7FFF_FFFF);
        send_word(swd_pkg::OP_PEEK, 32'sh8000_0000);
        send_word(swd_pkg::OP_DUMP, '0);
    endtask

    // Fill with extreme words, overflow, then peek and a full dump
    task automatic test_fill_to_full();
        send_word(swd_pkg::OP_PUSH, 32'sh8000_0000);
        send_word(swd_pkg::OP_PUSH, 32'sh7FFF_FFFF);
        send_word(swd_pkg::OP_PUSH, 32'sh0000_0000);
        send_word(swd_pkg::OP_PUSH, -32'sd1);
        send_word(swd_pkg::OP_PUSH, 32'sh5555_5555);
        send_word(swd_pkg::OP_PUSH, 32'shAAAA_AAAA);
        send_word(swd_pkg::OP_PUSH, 32'sd1);
        send_word(swd_pkg::OP_PUSH, 32'sd1);
        send_word(swd_pkg::OP_PUSH, 32'sd42);
        send_word(swd_pkg::OP_PEEK, '0);
        send_word(swd_pkg::OP_DUMP, '0);
    endtask

    // Delete at top, middle and bottom, duplicates, a miss
    task automatic test_remove_by_value();
        send_word(swd_pkg::OP_REMOVE, 32'sd1);
        send_word(swd_pkg::OP_REMOVE, 32'sh5555_5555);
        send_word(swd_pkg::OP_REMOVE, 32'sh8000_0000);
        send_word(swd_pkg::OP_REMOVE, 32'sd12345);
        send_word(swd_pkg::OP_PEEK, '0);
        send_word(swd_pkg::OP_REMOVE, 32'sd1);
        send_word(swd_pkg::OP_DUMP, '0);
    endtask

    function automatic logic signed [DW-1:0] pick_value(swd_pkg::opcode_t op);
        int roll;
        roll = $urandom_range(99);
        if (op == swd_pkg::OP_REMOVE && stack_fill > 0 && roll < 75)
            return stack_words[$urandom_range(stack_fill - 1)];
        if (roll < 35)
            return int'($urandom_range(6)) - 3;
        if (roll < 45)
            return roll[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return $urandom();
    endfunction

    // Random traffic drifting between empty and full
    task automatic test_random_traffic(int n_words, int idle_pct, int stall_pct);
        bit               filling;
        int               roll;
        swd_pkg::opcode_t op;
        filling       = 1'b1;
        req_idle_pct  = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int k = 0; k < n_words; k++)
        begin
            if (stack_fill == STACK_DEPTH && $urandom_range(2) == 0)
                filling = 1'b0;
            else if (stack_fill == 0 && $urandom_range(2) == 0)
                filling = 1'b1;
            roll = $urandom_range(99);
            if (filling)
                op = (roll < 55) ? swd_pkg::OP_PUSH : (roll < 75) ? swd_pkg::OP_REMOVE :
                     (roll < 88) ? swd_pkg::OP_PEEK : swd_pkg::OP_DUMP;
            else
                op = (roll < 15) ? swd_pkg::OP_PUSH : (roll < 70) ? swd_pkg::OP_REMOVE :
                     (roll < 86) ? swd_pkg::OP_PEEK : swd_pkg::OP_DUMP;
            send_word(op, pick_value(op));
        end
    endtask

    // Test sequence
    initial
    begin
        rst_n          <= 1'b0;
        req_bus.valid  <= 1'b0;
        req_bus.opcode <= swd_pkg::OP_PUSH;
        req_bus.value  <= '0;
        errors         = 0;
        idle_cycles    = 0;
        stack_fill     = 0;
        req_idle_pct   = 0;
        rsp_stall_pct  = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_stack();
        test_fill_to_full();
        req_idle_pct  = 30;
        rsp_stall_pct = 30;
        test_remove_by_value();

        test_random_traffic(110, 0, 0);
        test_random_traffic(150, 40, 40);
        test_random_traffic(150, 10, 15);

        // drain
        req_bus.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (pending_words.size() != 0)
        begin
            $error("%0d result words never arrived", pending_words.size());
            errors++;
        end
        if (errors == 0)
            $display("** stack_with_delete_by_value: PASSED **");
        else
            $display("** stack_with_delete_by_value: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/swd_pkg.sv
rtl/swd_req_if.sv
rtl/swd_rsp_if.sv
rtl/swd_cell.sv
rtl/stack_with_delete_by_value.sv
tb/sv/tb.sv
